// ----- src/rmsim_pkg.sv -----
// Shared types and constants of the three-phase RMS and imbalance meter.
package rmsim_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned GainW   = 16;
  localparam int unsigned RmsW    = 16;
  localparam int unsigned ImbW    = 15;
  localparam int unsigned TempAccW = 18;
  localparam int unsigned SqSumW  = 31;
  localparam int unsigned NumLanes = 6;

  localparam logic [1:0] CfgOffset = 2'd0;
  localparam logic [1:0] CfgCurGain = 2'd1;
  localparam logic [1:0] CfgVoltGain = 2'd2;

  localparam logic [SampleW-1:0] OffsetReset = 12'd2048;
  localparam logic [GainW-1:0]   GainReset   = 16'd4096;

  typedef struct packed {
    logic acc;
    logic start;
  } lane_ctrl_t;

endpackage

// ----- src/rmsim_div.sv -----
// Restoring divider, one quotient bit per cycle.
module rmsim_div #(
  parameter int unsigned W = 32,
  parameter int unsigned D = 18
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [D-1:0] divisor_i,
  output logic [W-1:0] quotient_o,
  output logic         done_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [D-1:0]  rem_q, den_q, rem_d;
  logic [W-1:0]  quo_q;
  logic [CW-1:0] cnt_q;
  logic          run_q, done_q;
  logic [D:0]    trial, diff;
  logic          ge;

  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[D-1:0] : trial[D-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(W);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;
endmodule

// ----- src/rmsim_isqrt.sv -----
// Root search for the lanes: largest r with N*r*r <= value, one root bit per cycle.
module rmsim_isqrt #(
  parameter int unsigned W = 39,
  parameter int unsigned R = 16,
  parameter int unsigned N = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] value_i,
  output logic [R-1:0] root_o,
  output logic         done_o
);
  localparam int unsigned CW   = $clog2(R + 1);
  localparam int unsigned SqW  = 2 * R;
  localparam int unsigned PW   = SqW + $clog2(N + 1);
  localparam int unsigned CmpW = (PW > W) ? PW : W;

  logic [W-1:0]    val_q;
  logic [R-1:0]    root_q, bit_q, cand;
  logic [SqW-1:0]  cand_sq;
  logic [CmpW-1:0] scaled;
  logic [CW-1:0]   cnt_q;
  logic            run_q, done_q, fits;

  // floor(sqrt(value / N)) without a divide: keep a bit if N*cand^2 still fits
  always_comb begin
    cand    = root_q | bit_q;
    cand_sq = SqW'(cand) * SqW'(cand);
    scaled  = CmpW'(cand_sq) * CmpW'(N);
    fits    = scaled <= CmpW'(val_q);
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      root_q <= '0;
      bit_q  <= {1'b1, {(R-1){1'b0}}};
    end else if (run_q) begin
      if (fits) root_q <= cand;
      bit_q <= bit_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(R);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;
endmodule

// ----- src/rmsim_lane.sv -----
// One AC channel: sum of squares, mean, square root and gain scaling.
module rmsim_lane #(
  parameter int unsigned N  = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rmsim_pkg::lane_ctrl_t       ctrl_i,
  input  logic [rmsim_pkg::SampleW-1:0] sample_i,
  input  logic [rmsim_pkg::SampleW-1:0] offset_i,
  input  logic [rmsim_pkg::GainW-1:0]   gain_i,
  output logic [rmsim_pkg::RmsW-1:0]    rms_o,
  output logic                        done_o
);
  import rmsim_pkg::*;

  localparam int unsigned ValW  = SqSumW + 8;
  localparam int unsigned ProdW = RmsW + GainW;

  logic signed [SampleW:0] diff;
  logic [SampleW:0]        mag_w;
  logic [2*SampleW-1:0]    sq;
  logic [SqSumW-1:0]       acc_q;
  logic                    sq_done;
  logic [RmsW-1:0]         root;
  logic [ProdW-1:0]        prod_q;
  logic                    done_q;

  always_comb begin
    diff  = $signed({1'b0, sample_i}) - $signed({1'b0, offset_i});
    mag_w = diff[SampleW] ? 13'(-diff) : 13'(diff);
    sq    = mag_w[SampleW-1:0] * mag_w[SampleW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.start) begin
      acc_q <= '0;
    end else if (ctrl_i.acc) begin
      acc_q <= acc_q + SqSumW'(sq);
    end
  end

  // Q4 rms = floor(sqrt(sum * 256 / N))
  rmsim_isqrt #(.W(ValW), .R(RmsW), .N(N)) u_sqrt (
    .clk_i, .rst_ni,
    .start_i(ctrl_i.start),
    .value_i({acc_q, 8'h00}),
    .root_o (root),
    .done_o (sq_done)
  );

  always_ff @(posedge clk_i) begin
    if (sq_done) begin
      prod_q <= ProdW'(root) * ProdW'(gain_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= sq_done;
    end
  end

  assign rms_o  = prod_q[ProdW-1:GainW];
  assign done_o = done_q;
endmodule

// ----- src/rmsim_merge.sv -----
// Merge stage: temperature mean and voltage imbalance from the lane results.
module rmsim_merge #(
  parameter int unsigned N  = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rmsim_pkg::TempAccW-1:0] temp_acc_i,
  input  logic                           lanes_done_i,
  input  logic [rmsim_pkg::RmsW-1:0]     vr_i,
  input  logic [rmsim_pkg::RmsW-1:0]     vy_i,
  input  logic [rmsim_pkg::RmsW-1:0]     vb_i,
  output logic                           res_valid_o,
  output logic [rmsim_pkg::SampleW-1:0]  temp_avg_o,
  output logic [rmsim_pkg::ImbW-1:0]     imb_o
);
  import rmsim_pkg::*;

  // temp / N as a multiply by ceil(2^TShift / N), exact for any 18-bit sum
  localparam int unsigned TShift = TempAccW + $clog2(N);
  localparam int unsigned TProdW = TempAccW + TShift;
  localparam logic [TShift-1:0] TRecip =
    TShift'(((64'd1 << TShift) + 64'(N) - 64'd1) / 64'(N));

  typedef enum logic [2:0] {S_IDLE, S_SUM, S_DEV, S_MUL, S_WAIT} state_e;

  state_e             state_q;
  logic [TProdW-1:0]  tprod;
  logic               idone;
  logic [SampleW-1:0] temp_q;
  logic [17:0]        sum_q, t_q [3], dev [3], worst;
  logic [17:0]        worst_q;
  logic [31:0]        prod_q, iq;
  logic               dstart_q, valid_q;
  logic [ImbW-1:0]    imb_q;

  rmsim_div #(.W(32), .D(18)) u_idiv (
    .clk_i, .rst_ni,
    .start_i   (dstart_q),
    .dividend_i(prod_q),
    .divisor_i (sum_q),
    .quotient_o(iq),
    .done_o    (idone)
  );

  assign tprod = TProdW'(temp_acc_i) * TProdW'(TRecip);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      temp_q <= tprod[TShift +: SampleW];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dev[i] = (t_q[i] > sum_q) ? t_q[i] - sum_q : sum_q - t_q[i];
    end
    worst = dev[0];
    if (dev[1] > worst) worst = dev[1];
    if (dev[2] > worst) worst = dev[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      dstart_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      dstart_q <= 1'b0;
      valid_q  <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (lanes_done_i) state_q <= S_SUM;
        end
        S_SUM: begin
          sum_q   <= 18'(vr_i) + 18'(vy_i) + 18'(vb_i);
          t_q[0]  <= 18'(vr_i) * 18'd3;
          t_q[1]  <= 18'(vy_i) * 18'd3;
          t_q[2]  <= 18'(vb_i) * 18'd3;
          state_q <= S_DEV;
        end
        S_DEV: begin
          worst_q <= worst;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q   <= 32'(worst_q) * 32'd10000;
          dstart_q <= 1'b1;
          state_q  <= S_WAIT;
        end
        S_WAIT: begin
          if (idone) begin
            imb_q   <= (sum_q == '0) ? '0 : iq[ImbW-1:0];
            valid_q <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = valid_q;
  assign temp_avg_o  = temp_q;
  assign imb_o       = imb_q;
endmodule

// ----- src/three_phase_rms_imbalance_meter_unit.sv -----
// Three-phase true-RMS and imbalance meter, top level.
// A scan word is taken on each handshake. After the window's last scan the six
// lanes run a bitwise root search and the merge stage a restoring divide;
// s_axis_tready is low from that scan until the result word is valid. The next
// window's last scan waits while a result word is still held. Reset clears
// accumulators and counter and sets offset 2048 and both gains 4096.
module three_phase_rms_imbalance_meter_unit #(
  parameter int unsigned SAMPLES_PER_WINDOW = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // temp, ct_r, ct_y, ct_b, pt_r, pt_y, pt_b (12 bits each), zero pad
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // temp_average(12), current r/y/b rms, voltage r/y/b rms (16 each),
  // imbalance_centipercent(15), zero pad
  output logic [127:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i
);
  import rmsim_pkg::*;

  localparam int unsigned N  = SAMPLES_PER_WINDOW;
  localparam int unsigned CW = $clog2(N + 1);

  logic [SampleW-1:0]  offset_q;
  logic [GainW-1:0]    cgain_q, vgain_q;
  logic [CW-1:0]       count_q;
  logic [TempAccW-1:0] temp_q;
  logic                fin_q, busy_q, out_valid_q;
  logic [127:0]        out_q;
  logic                s_acc, last;
  lane_ctrl_t          ctrl;
  logic [RmsW-1:0]     rms [NumLanes];
  logic [NumLanes-1:0] ldone;
  logic                res_valid;
  logic [SampleW-1:0]  temp_avg;
  logic [ImbW-1:0]     imb;

  assign last          = count_q == CW'(N - 1);
  assign s_axis_tready = !busy_q && !(out_valid_q && last);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign ctrl          = '{acc: s_acc, start: fin_q};
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
      cgain_q  <= GainReset;
      vgain_q  <= GainReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgOffset:   offset_q <= cfg_data_i[SampleW-1:0];
        CfgCurGain:  cgain_q  <= cfg_data_i;
        CfgVoltGain: vgain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      temp_q      <= '0;
      fin_q       <= 1'b0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fin_q <= 1'b0;
      if (fin_q) begin
        temp_q <= '0;
      end else if (s_acc) begin
        temp_q <= temp_q + TempAccW'(s_axis_tdata[11:0]);
      end
      if (s_acc) begin
        if (last) begin
          count_q <= '0;
          fin_q   <= 1'b1;
          busy_q  <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end
      if (res_valid) begin
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    rmsim_lane #(.N(N)) u_lane (
      .clk_i, .rst_ni,
      .ctrl_i  (ctrl),
      .sample_i(s_axis_tdata[SampleW*(i+1) +: SampleW]),
      .offset_i(offset_q),
      .gain_i  ((i < 3) ? cgain_q : vgain_q),
      .rms_o   (rms[i]),
      .done_o  (ldone[i])
    );
  end

  rmsim_merge #(.N(N)) u_merge (
    .clk_i, .rst_ni,
    .start_i     (fin_q),
    .temp_acc_i  (temp_q),
    .lanes_done_i(ldone[0]),
    .vr_i        (rms[3]),
    .vy_i        (rms[4]),
    .vb_i        (rms[5]),
    .res_valid_o (res_valid),
    .temp_avg_o  (temp_avg),
    .imb_o       (imb)
  );

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= {5'b0, imb, rms[5], rms[4], rms[3], rms[2], rms[1], rms[0], temp_avg};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
endmodule

// ----- src/rmsim_checker.sv -----
// Port-level checks of the meter's result stream, bound to the top level.
module rmsim_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed while stalled");

  a_imb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[122:108] <= 15'd20000)
    else $error("imbalance above 200 percent");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("back-to-back result words");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[127:123] == 5'd0)
    else $error("nonzero pad bits");
endmodule

bind three_phase_rms_imbalance_meter_unit rmsim_checker u_rmsim_checker (.*);

// ----- verif/tb_three_phase_rms_imbalance_meter_unit.sv -----
// Testbench of the three-phase RMS and imbalance meter: random scans, checked per window.
module tb_three_phase_rms_imbalance_meter_unit;
  import rmsim_pkg::*;

  localparam int unsigned WindowLen = 64;
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int unsigned SettleCycles = 150;
  localparam int unsigned LongHoldCycles = 3000;

  typedef logic [SampleW-1:0] scan_t [7];

  typedef struct packed {
    logic [ImbW-1:0]            imbalance;
    logic [NumLanes-1:0][RmsW-1:0] rms;
    logic [SampleW-1:0]         temp_avg;
  } reading_t;

  typedef enum int {WaveUniform, WaveNearBias, WaveRails} wave_e;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [15:0]  cfg_data_i;

  // predictor state
  logic [SampleW-1:0]  offset_reg;
  logic [GainW-1:0]    cur_gain_reg;
  logic [GainW-1:0]    volt_gain_reg;
  logic [TempAccW-1:0] temp_total;
  logic [SqSumW-1:0]   sq_sums [NumLanes];
  int unsigned         scans_in_window;

  reading_t    expected_readings [$];
  int unsigned error_count;
  bit          burst_send;
  bit          long_hold_req;

  three_phase_rms_imbalance_meter_unit #(
    .SAMPLES_PER_WINDOW(WindowLen)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic logic [31:0] floor_root(logic [63:0] v);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if ({32'd0, c} * {32'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [RmsW-1:0] scale_rms(logic [SqSumW-1:0] sq, logic [GainW-1:0] g);
    logic [63:0] mean_q8;
    logic [63:0] prod;
    mean_q8 = ({33'd0, sq} * 64'd256) / WindowLen;
    prod = {32'd0, floor_root(mean_q8)} * {48'd0, g};
    return prod[16 +: RmsW];
  endfunction

  task automatic accumulate_scan(scan_t s);
    int signed d;
    reading_t r;
    logic [31:0] v_sum;
    logic [31:0] worst;
    logic [31:0] t;
    logic [31:0] dev;
    temp_total = temp_total + s[0];
    for (int i = 0; i < NumLanes; i++) begin
      d = int'(s[i+1]) - int'(offset_reg);
      if (d < 0) d = -d;
      sq_sums[i] = sq_sums[i] + SqSumW'(d * d);
    end
    scans_in_window++;
    if (scans_in_window < WindowLen) return;
    r.temp_avg = SampleW'(temp_total / WindowLen);
    for (int i = 0; i < 3; i++) r.rms[i] = scale_rms(sq_sums[i], cur_gain_reg);
    for (int i = 3; i < 6; i++) r.rms[i] = scale_rms(sq_sums[i], volt_gain_reg);
    v_sum = r.rms[3] + r.rms[4] + r.rms[5];
    worst = 0;
    r.imbalance = '0;
    if (v_sum != 0) begin
      for (int i = 3; i < 6; i++) begin
        t = 3 * r.rms[i];
        dev = (t > v_sum) ? t - v_sum : v_sum - t;
        if (dev > worst) worst = dev;
      end
      r.imbalance = ImbW'((64'(worst) * 64'd10000) / v_sum);
    end
    expected_readings.push_back(r);
    temp_total = '0;
    for (int i = 0; i < NumLanes; i++) sq_sums[i] = '0;
    scans_in_window = 0;
  endtask

  task automatic send_scan(scan_t s);
    int unsigned gap;
    logic [87:0] word;
    gap = burst_send ? 0 : $urandom_range(17);
    word = '0;
    for (int i = 0; i < 7; i++) word[i*SampleW +: SampleW] = s[i];
    word[87:84] = 4'($urandom_range(15));  // pad bits must be ignored
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    accumulate_scan(s);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait (expected_readings.size() == 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b1;
    cfg_index_i   <= idx;
    cfg_data_i    <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgOffset:   offset_reg = val[SampleW-1:0];
      CfgCurGain:  cur_gain_reg = val;
      CfgVoltGain: volt_gain_reg = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic make_scan(wave_e w, output scan_t s);
    for (int i = 0; i < 7; i++) begin
      case (w)
        WaveUniform: s[i] = SampleW'($urandom_range(4095));
        WaveNearBias: s[i] = SampleW'(int'(offset_reg) + $urandom_range(200) - 100);
        default: s[i] = $urandom_range(1) ? 12'hFFF : 12'h000;
      endcase
    end
  endtask

  task automatic send_window(wave_e w);
    scan_t s;
    for (int n = 0; n < WindowLen; n++) begin
      make_scan(w, s);
      send_scan(s);
    end
  endtask

  task automatic send_flat_window(logic [SampleW-1:0] temp, logic [SampleW-1:0] ac);
    scan_t s;
    s[0] = temp;
    for (int i = 1; i < 7; i++) s[i] = ac;
    repeat (WindowLen) send_scan(s);
  endtask

  task automatic test_reset_defaults();
    send_window(WaveUniform);
  endtask

  // full-scale swings with the widest gains, then zero sums
  task automatic test_extremes();
    write_reg(CfgOffset, 16'hF000);
    write_reg(CfgCurGain, 16'hFFFF);
    write_reg(CfgVoltGain, 16'hFFFF);
    send_flat_window(12'hFFF, 12'hFFF);
    write_reg(CfgOffset, 16'h0FFF);
    send_flat_window(12'h000, 12'h000);
    send_flat_window(12'h123, 12'hFFF);
    send_window(WaveRails);
  endtask

  task automatic test_zero_voltage_sum();
    write_reg(CfgOffset, 16'd1000);
    write_reg(CfgVoltGain, 16'd0);
    send_window(WaveUniform);
    write_reg(CfgVoltGain, 16'd30000);
    send_flat_window(12'd77, 12'd1000);
  endtask

  // offset changes inside a window; gain changes land before the result
  task automatic test_mid_window_writes();
    scan_t s;
    for (int n = 0; n < WindowLen; n++) begin
      if (n == 20) write_reg(CfgOffset, 16'd2500);
      if (n == 40) write_reg(CfgCurGain, 16'd12345);
      if (n == 50) write_reg(CfgUnused, 16'hABCD);
      make_scan(WaveUniform, s);
      send_scan(s);
    end
  endtask

  task automatic test_backpressure();
    burst_send = 1'b1;
    long_hold_req = 1'b1;
    repeat (3) send_window(WaveUniform);
    burst_send = 1'b0;
  endtask

  task automatic test_random_windows();
    wave_e w;
    for (int k = 0; k < 15; k++) begin
      case ($urandom_range(5))
        0: write_reg(CfgOffset, 16'($urandom_range(65535)));
        1: write_reg(CfgCurGain, 16'($urandom_range(65535)));
        2: write_reg(CfgVoltGain, 16'($urandom_range(65535)));
        3: write_reg(CfgUnused, 16'($urandom_range(65535)));
        default: ;
      endcase
      burst_send = ($urandom_range(3) == 0);
      case ($urandom_range(5))
        0: w = WaveRails;
        1, 2: w = WaveNearBias;
        default: w = WaveUniform;
      endcase
      send_window(w);
    end
    burst_send = 1'b0;
  endtask

  // receiver: random stalls, one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if ($urandom_range(3) != 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(17)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    reading_t got;
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(reading_t)-1:0];
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected word %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = expected_readings.pop_front();
        if (got.temp_avg !== want.temp_avg) begin
          $display("%0t: temp_average exp %0d got %0d", $time, want.temp_avg, got.temp_avg);
          error_count++;
        end
        for (int i = 0; i < NumLanes; i++) begin
          if (got.rms[i] !== want.rms[i]) begin
            $display("%0t: rms lane %0d exp %0d got %0d", $time, i, want.rms[i], got.rms[i]);
            error_count++;
          end
        end
        if (got.imbalance !== want.imbalance) begin
          $display("%0t: imbalance exp %0d got %0d", $time, want.imbalance, got.imbalance);
          error_count++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    error_count = 0;
    burst_send = 1'b0;
    long_hold_req = 1'b0;
    offset_reg = OffsetReset;
    cur_gain_reg = GainReset;
    volt_gain_reg = GainReset;
    temp_total = '0;
    for (int i = 0; i < NumLanes; i++) sq_sums[i] = '0;
    scans_in_window = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgOffset;
    cfg_data_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_extremes();
    test_zero_voltage_sum();
    test_mid_window_writes();
    test_backpressure();
    test_random_windows();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/rmsim_pkg.sv
src/rmsim_div.sv
src/rmsim_isqrt.sv
src/rmsim_lane.sv
src/rmsim_merge.sv
src/three_phase_rms_imbalance_meter_unit.sv
src/rmsim_checker.sv
verif/tb_three_phase_rms_imbalance_meter_unit.sv
